// ===== rtl/core/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

	localparam int WORD_W   = 32;
	localparam int POS_W    = 8;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	// Command codes; codes five to seven are no-ops.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_BADPOS   = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row for one cycle.
	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
		logic rd;
	} cell_op_t;

endpackage

// ===== rtl/core/pal_cmd_if.sv =====
`timescale 1ns / 1ps

interface pal_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [7:0]         pos;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output pos, output value, input ready);
	modport sink   (input valid, input cmd, input pos, input value, output ready);
endinterface

// ===== rtl/core/pal_res_if.sv =====
`timescale 1ns / 1ps

interface pal_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [7:0]         count;
	logic               empty_res;
	logic               full_res;

	modport source (output valid, output status, output data_out, output count,
		output empty_res, output full_res, input ready);
	modport sink   (input valid, input status, input data_out, input count,
		input empty_res, input full_res, output ready);
endinterface

// ===== rtl/core/pal_cell.sv =====
`timescale 1ns / 1ps

module pal_cell #(
	parameter int SEL_W = 8,
	parameter int IDX   = 0
) (
	input  logic                      clk,
	input  pal_pkg::cell_op_t         op,
	input  logic [SEL_W-1:0]          sel,
	input  logic [pal_pkg::WORD_W-1:0] value,
	input  logic [pal_pkg::WORD_W-1:0] prev_word,
	input  logic [pal_pkg::WORD_W-1:0] next_word,
	output logic [pal_pkg::WORD_W-1:0] word,
	output logic [pal_pkg::WORD_W-1:0] tap
);
	import pal_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_nxt;
	logic              hit;
	logic              above;

	assign hit   = (sel == SEL_W'(IDX));
	assign above = (SEL_W'(IDX) > sel);

	// Insert moves entries above the target up, delete pulls the target
	// and everything above it down from the right-hand neighbor.
	always_comb begin
		word_nxt = word_q;
		if (op.wr && hit) begin
			word_nxt = value;
		end else if (op.ins && above) begin
			word_nxt = prev_word;
		end else if (op.del && (above || hit)) begin
			word_nxt = next_word;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;
	assign tap  = (op.rd && hit) ? word_q : '0;

endmodule

// ===== rtl/core/positional_array_list.sv =====
`timescale 1ns / 1ps
// An accepted request is decoded into stage 1, applied to the cell row and stage 2,
// then loaded into the output register once that is free. The next request is taken
// once the previous one has left the cell row and its two-level read tree.
// Reset (arst_n low) empties the list and clears all valid flags; the entry
// words themselves are not cleared and are readable only once written.
module positional_array_list #(
	parameter int CAPACITY = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	pal_cmd_if.sink    request,
	pal_res_if.source  result
);
	import pal_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int SEL_W = (LEN_W > POS_W) ? LEN_W : POS_W;
	localparam int GROUP = 8;
	localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

	// The list length is the only control state of the row; each cell holds
	// the entry at its own position.
	logic [LEN_W-1:0] length_q;

	// Stage 1: decoded request, waiting to be applied to the cell row.
	logic             v_s1;
	cell_op_t         op_s1;
	logic [SEL_W-1:0] sel_s1;
	status_t          st_s1;
	logic [LEN_W-1:0] len_s1;
	logic [WORD_W-1:0] value_s1;

	// Stage 2: row updated, read taps folded into per-group words.
	logic             v_s2;
	status_t          st_s2;
	logic [LEN_W-1:0] len_s2;
	logic [WORD_W-1:0] grp_s2 [NGRP];

	// Output register.
	logic             out_valid_q;
	status_t          status_q;
	logic [WORD_W-1:0] data_q;
	logic [LEN_W-1:0] len_q;

	logic             accept;
	logic             load_out;
	cell_op_t         op_d;
	logic [SEL_W-1:0] sel_d;
	status_t          st_d;
	logic [LEN_W-1:0] len_d;
	logic [SEL_W-1:0] len_ext;
	logic [SEL_W-1:0] pos_ext;
	logic             list_full;
	cell_op_t         cell_op;
	logic [WORD_W-1:0] grp_or [NGRP];
	logic [WORD_W-1:0] data_or;

	logic [WORD_W-1:0] words [CAPACITY];
	logic [WORD_W-1:0] taps  [CAPACITY];

	// Only one request is inside the internal stages at a time, so a new one waits until the
	// previous request has passed both internal stages.
	assign request.ready = !v_s1 && !v_s2;
	assign accept        = request.valid && request.ready;
	assign load_out      = v_s2 && (!out_valid_q || result.ready);

	// Decode against the current length. The full check comes before the
	// position check for insert, and a failing request changes nothing.
	assign len_ext   = SEL_W'(length_q);
	assign pos_ext   = SEL_W'(request.pos);
	assign list_full = (length_q == LEN_W'(CAPACITY));

	always_comb begin
		op_d  = '0;
		sel_d = pos_ext;
		st_d  = ST_OK;
		len_d = length_q;
		case (cmd_t'(request.cmd))
			CMD_CLEAR: begin
				len_d = '0;
			end
			CMD_INSERT: begin
				if (list_full) begin
					st_d = ST_OVERFLOW;
				end else if (pos_ext > len_ext) begin
					st_d = ST_BADPOS;
				end else begin
					op_d.ins = 1'b1;
					op_d.wr  = 1'b1;
					len_d    = length_q + LEN_W'(1);
				end
			end
			CMD_APPEND: begin
				if (list_full) begin
					st_d = ST_OVERFLOW;
				end else begin
					op_d.wr = 1'b1;
					sel_d   = len_ext;
					len_d   = length_q + LEN_W'(1);
				end
			end
			CMD_DELETE: begin
				if (pos_ext >= len_ext) begin
					st_d = ST_BADPOS;
				end else begin
					op_d.del = 1'b1;
					op_d.rd  = 1'b1;
					len_d    = length_q - LEN_W'(1);
				end
			end
			CMD_READ: begin
				if (pos_ext >= len_ext) begin
					st_d = ST_BADPOS;
				end else begin
					op_d.rd = 1'b1;
				end
			end
			default: begin
				// Unused codes leave the list as it is and report ok.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			op_s1 <= '0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				op_s1 <= op_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1   <= sel_d;
			st_s1    <= st_d;
			len_s1   <= len_d;
			value_s1 <= request.value;
		end
	end

	// The operation reaches the row for exactly one cycle.
	assign cell_op = v_s1 ? op_s1 : '0;

	genvar i;
	for (i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w;
		logic [WORD_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = words[i];
		end else begin : g_mid_prev
			assign prev_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = words[i+1];
		end
		pal_cell #(
			.SEL_W (SEL_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.sel       (sel_s1),
			.value     (value_s1),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (words[i]),
			.tap       (taps[i])
		);
	end

	// First level of the read tree: only the addressed cell drives a nonzero
	// tap, and it is sampled before the shift lands in the row.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | taps[g * GROUP + k];
				end
			end
		end
	end

	always_comb begin
		data_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			data_or = data_or | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (v_s1) begin
				length_q <= len_s1;
				v_s2     <= 1'b1;
			end else if (load_out) begin
				v_s2 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			st_s2  <= st_s1;
			len_s2 <= len_s1;
			for (int g = 0; g < NGRP; g++) begin
				grp_s2[g] <= grp_or[g];
			end
		end
		if (load_out) begin
			status_q <= st_s2;
			data_q   <= data_or;
			len_q    <= len_s2;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = status_q;
	assign result.data_out  = data_q;
	assign result.count     = COUNT_W'(len_q);
	assign result.empty_res = (len_q == '0);
	assign result.full_res  = (len_q == LEN_W'(CAPACITY));

	// At most one request is between the decode and the output register.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2))
		else $error("two requests inside the cell row pipeline");

	// The length never exceeds the number of cells.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	// An overflow is only reported against a full list.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_OVERFLOW) |-> result.full_res)
		else $error("overflow reported on a list that is not full");

	// A rejected position never returns a word from the row.
	a_badpos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_BADPOS) |-> (result.data_out == '0))
		else $error("bad position returned nonzero data");

endmodule
